// ----- sv/accel_tilt_angles_core_assert.svh -----
// Assertion macros used by the tilt-angle controller (ata_ctrl).
// Expects clk and rst_n to be in scope where the macros are used.
`ifndef ACCEL_TILT_ANGLES_CORE_ASSERT_SVH
`define ACCEL_TILT_ANGLES_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ATA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ATA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ata_pkg.sv -----
// Shared widths, constants, command/status structs and the CORDIC angle table
// for the tilt-angle block. No dependencies.
package ata_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int BYTE_W   = 8;
  localparam int RAW_W    = 16;
  localparam int AXIS_W   = 17;          // raw minus offset
  localparam int SQ_W     = 32;          // square of a calibrated axis
  localparam int SUM_W    = 33;          // sum of two squares
  localparam int FRAC_SH  = 28;          // radicand scaling
  localparam int RAD_W    = 62;
  localparam int ROOT_W   = 31;
  localparam int REM_W    = 33;
  localparam int ROOT_STEPS   = 31;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W   = 5;
  localparam int Y_SH     = 14;          // numerator scaling
  localparam int XY_W     = 36;
  localparam int Z_W      = 32;
  localparam int ATAN_W   = 29;
  localparam int RND_SH   = 16;
  localparam int ANG_W    = 15;
  localparam int SAMPLE_W = 32;

  localparam logic signed [ANG_W-1:0] ANGLE_MAX = 15'sd9000;
  localparam logic signed [Z_W-1:0]   ROUND_HALF = 32'sd32768;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 2'd2;

  typedef struct packed {
    logic              load;       // latch calibrated axes
    logic              square;     // register axis squares
    logic              setup;      // start square root
    logic              root_step;  // one root digit
    logic              prep;       // start CORDIC
    logic              rotate;     // one CORDIC iteration
    logic              finish;     // round, clamp, store angles
    logic              emit;       // load output beat
    logic              upd;        // angles refreshed by this sample
    logic [STEP_W-1:0] step;
  } ata_cmd_t;

  typedef struct packed {
    logic all_zero;
  } ata_sts_t;

  // atan(2^-i) in 2^-16 hundredths of a degree
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 29'd294912000;
      5'd1:    v = 29'd174096719;
      5'd2:    v = 29'd91987925;
      5'd3:    v = 29'd46694507;
      5'd4:    v = 29'd23437865;
      5'd5:    v = 29'd11730358;
      5'd6:    v = 29'd5866610;
      5'd7:    v = 29'd2933484;
      5'd8:    v = 29'd1466764;
      5'd9:    v = 29'd733385;
      5'd10:   v = 29'd366693;
      5'd11:   v = 29'd183346;
      5'd12:   v = 29'd91673;
      5'd13:   v = 29'd45837;
      5'd14:   v = 29'd22918;
      5'd15:   v = 29'd11459;
      5'd16:   v = 29'd5730;
      5'd17:   v = 29'd2865;
      5'd18:   v = 29'd1432;
      5'd19:   v = 29'd716;
      5'd20:   v = 29'd358;
      5'd21:   v = 29'd179;
      5'd22:   v = 29'd90;
      5'd23:   v = 29'd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/ata_angle_lane.sv -----
// One angle lane: bit-serial integer square root followed by a vectoring CORDIC.
// Depends on ata_pkg.
module ata_angle_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ata_pkg::ata_cmd_t                    cmd,
  input  logic signed [ata_pkg::AXIS_W-1:0]    num,
  input  logic        [ata_pkg::SUM_W-1:0]     sum,
  output logic signed [ata_pkg::ANG_W-1:0]     angle
);
  import ata_pkg::*;

  logic        [RAD_W-1:0]  rad_r, rad_nxt;
  logic        [ROOT_W-1:0] root_r, root_nxt;
  logic        [REM_W-1:0]  rem_r, rem_nxt;
  logic signed [XY_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]    z_r, z_nxt;
  logic signed [ANG_W-1:0]  angle_r, angle_nxt;

  logic        [REM_W+1:0]  rem_sh, trial;
  logic        [AXIS_W-1:0] mag;
  logic signed [XY_W-1:0]   dx, dy;
  logic signed [Z_W-1:0]    z_rnd;
  logic signed [Z_W-RND_SH-1:0] r_full;
  logic signed [ANG_W-1:0]  r_clamp;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign mag    = num[AXIS_W-1] ? -num : num;
  assign dx     = y_r >>> cmd.step;
  assign dy     = x_r >>> cmd.step;
  assign z_rnd  = z_r + ROUND_HALF;
  assign r_full = z_rnd[Z_W-1:RND_SH];

  always_comb begin
    if (r_full > ANGLE_MAX) begin
      r_clamp = ANGLE_MAX;
    end else if (r_full < -ANGLE_MAX) begin
      r_clamp = -ANGLE_MAX;
    end else begin
      r_clamp = r_full[ANG_W-1:0];
    end
  end

  always_comb begin
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    angle_nxt = angle_r;
    if (cmd.setup) begin
      rad_nxt  = RAD_W'({sum, {FRAC_SH{1'b0}}});
      root_nxt = '0;
      rem_nxt  = '0;
    end
    if (cmd.root_step) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = REM_W'(rem_sh - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.prep) begin
      x_nxt = XY_W'(root_r);
      y_nxt = XY_W'({mag, {Y_SH{1'b0}}});
      z_nxt = '0;
    end
    if (cmd.rotate) begin
      if (!y_r[XY_W-1]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + Z_W'(atan_lut(cmd.step));
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - Z_W'(atan_lut(cmd.step));
      end
    end
    if (cmd.finish) begin
      angle_nxt = num[AXIS_W-1] ? -r_clamp : r_clamp;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  // stored angle survives 0/0 samples, so it is state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else begin
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;

endmodule

// ----- sv/ata_datapath.sv -----
// Datapath: offset registers, calibration, squares, two angle lanes, sample
// counter and the output beat register. Depends on ata_pkg and ata_angle_lane.
module ata_datapath #(
  parameter int COUNT_WIDTH = ata_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic        [ata_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ata_pkg::RAW_W-1:0]      cfg_data,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_x_low,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_x_high,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_y_low,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_y_high,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_z_low,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_z_high,
  input  ata_pkg::ata_cmd_t                     cmd,
  output ata_pkg::ata_sts_t                     sts,
  output logic signed [ata_pkg::ANG_W-1:0]      out_tilt_about_x,
  output logic signed [ata_pkg::ANG_W-1:0]      out_tilt_about_y,
  output logic                                  out_updated,
  output logic        [ata_pkg::SAMPLE_W-1:0]   out_sample_count
);
  import ata_pkg::*;

  logic signed [RAW_W-1:0]    x_off_r, y_off_r, z_off_r;
  logic signed [RAW_W-1:0]    rx, ry, rz;
  logic signed [AXIS_W-1:0]   cx_r, cy_r, cz_r;
  logic signed [2*AXIS_W-1:0] prod_x, prod_y, prod_z;
  logic        [SQ_W-1:0]     sqx_r, sqy_r, sqz_r;
  logic        [SUM_W-1:0]    sum_xz, sum_yz;
  logic        [COUNT_WIDTH-1:0] count_r;
  logic signed [ANG_W-1:0]    ang_x, ang_y;
  logic signed [ANG_W-1:0]    tilt_x_r, tilt_y_r;
  logic                       upd_r;
  logic        [SAMPLE_W-1:0] cnt_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= '0;
      y_off_r <= '0;
      z_off_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_OFFSET: x_off_r <= cfg_data;
        REG_Y_OFFSET: y_off_r <= cfg_data;
        REG_Z_OFFSET: z_off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx = {in_x_high, in_x_low};
  assign ry = {in_y_high, in_y_low};
  assign rz = {in_z_high, in_z_low};

  assign prod_x = cx_r * cx_r;
  assign prod_y = cy_r * cy_r;
  assign prod_z = cz_r * cz_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= AXIS_W'(rx) - AXIS_W'(x_off_r);
      cy_r <= AXIS_W'(ry) - AXIS_W'(y_off_r);
      cz_r <= AXIS_W'(rz) - AXIS_W'(z_off_r);
    end
    if (cmd.square) begin
      sqx_r <= prod_x[SQ_W-1:0];
      sqy_r <= prod_y[SQ_W-1:0];
      sqz_r <= prod_z[SQ_W-1:0];
    end
  end

  assign sts.all_zero = (cx_r == '0) && (cy_r == '0) && (cz_r == '0);

  assign sum_xz = SUM_W'(sqx_r) + SUM_W'(sqz_r);
  assign sum_yz = SUM_W'(sqy_r) + SUM_W'(sqz_r);

  // tilt about X: atan(cy / |(cx,cz)|)
  ata_angle_lane u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .num   (cy_r),
    .sum   (sum_xz),
    .angle (ang_x)
  );

  // tilt about Y: atan(cx / |(cy,cz)|)
  ata_angle_lane u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .num   (cx_r),
    .sum   (sum_yz),
    .angle (ang_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish) begin
      count_r <= count_r + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tilt_x_r  <= ang_x;
      tilt_y_r  <= ang_y;
      upd_r     <= cmd.upd;
      cnt_out_r <= SAMPLE_W'(count_r);
    end
  end

  assign out_tilt_about_x = tilt_x_r;
  assign out_tilt_about_y = tilt_y_r;
  assign out_updated      = upd_r;
  assign out_sample_count = cnt_out_r;

endmodule

// ----- sv/ata_ctrl.sv -----
// Controller: sequences load, squares, root digits, CORDIC iterations and the
// output beat; owns both handshakes. Depends on ata_pkg and the assert header.
`include "accel_tilt_angles_core_assert.svh"

module ata_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ata_pkg::ata_sts_t   sts,
  output ata_pkg::ata_cmd_t   cmd
);
  import ata_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQUARE = 8'b0000_0010,
    ST_SETUP  = 8'b0000_0100,
    ST_ROOT   = 8'b0000_1000,
    ST_PREP   = 8'b0001_0000,
    ST_ROTATE = 8'b0010_0000,
    ST_FINISH = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } ata_state_t;

  ata_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              upd_r, upd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    upd_nxt       = upd_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.step      = step_r;
    cmd.upd       = upd_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        upd_nxt    = !sts.all_zero;
        // 0/0 sample: skip the math, resend stored angles
        state_nxt  = sts.all_zero ? ST_EMIT : ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_PREP;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_ROTATE;
      end
      ST_ROTATE: begin
        cmd.rotate = 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `ATA_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state_r == ST_SQUARE, "accepted beat did not start the sequence")
  `ATA_ASSERT_IMP(a_root_len, state_r == ST_PREP, $past(state_r) == ST_ROOT && $past(step_r) == STEP_W'(ROOT_STEPS - 1), "square root left early")
  `ATA_ASSERT_IMP(a_cordic_len, state_r == ST_FINISH, $past(state_r) == ST_ROTATE && $past(step_r) == STEP_W'(CORDIC_STEPS - 1), "CORDIC left early")
  `ATA_ASSERT_NXT(a_no_overwrite, state_r == ST_EMIT && out_valid_r && out_stall, state_r == ST_EMIT && out_valid_r, "pending output beat overwritten")

endmodule

// ----- sv/accel_tilt_angles_core.sv -----
// Tilt-angle core, top level.
// Input channel (in_valid/in_stall) takes one accelerometer sample per beat: six
// bytes, little-endian signed 16-bit X, Y, Z. Output channel (out_valid/out_stall)
// returns one beat per sample: tilt about X and Y in 0.01 degree, an updated
// flag and the sample count. Offsets are written on cfg_we with cfg_index 0..2
// (X, Y, Z); write them only while the core is idle.
// A sample with any nonzero calibrated axis runs through load, squares, root setup,
// the square root (one root bit per cycle), CORDIC setup, the 24-iteration CORDIC,
// rounding and clamping, and the output beat; the core takes the next sample after
// that beat is loaded. Both angles are computed side by side. An all-zero sample
// skips the math and goes from its squares straight to the output beat.
// in_stall is low only while the sequencer is idle; a sample is accepted while an
// earlier result still waits in the output register.
// If the receiver stalls, the output beat holds; a finished sample waits in its
// final state until the output register frees, and input stays stalled.
// Synchronous active-low reset clears offsets, stored angles, counter and valid.
// Depends on ata_pkg, ata_ctrl, ata_datapath.
module accel_tilt_angles_core #(
  parameter int COUNT_WIDTH = ata_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic        [ata_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ata_pkg::RAW_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_x_low,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_x_high,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_y_low,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_y_high,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_z_low,
  input  logic        [ata_pkg::BYTE_W-1:0]     in_z_high,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ata_pkg::ANG_W-1:0]      out_tilt_about_x,
  output logic signed [ata_pkg::ANG_W-1:0]      out_tilt_about_y,
  output logic                                  out_updated,
  output logic        [ata_pkg::SAMPLE_W-1:0]   out_sample_count
);
  import ata_pkg::*;

  ata_cmd_t cmd;
  ata_sts_t sts;

  ata_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ata_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_x_low         (in_x_low),
    .in_x_high        (in_x_high),
    .in_y_low         (in_y_low),
    .in_y_high        (in_y_high),
    .in_z_low         (in_z_low),
    .in_z_high        (in_z_high),
    .cmd              (cmd),
    .sts              (sts),
    .out_tilt_about_x (out_tilt_about_x),
    .out_tilt_about_y (out_tilt_about_y),
    .out_updated      (out_updated),
    .out_sample_count (out_sample_count)
  );

endmodule
